// ----- rtl/pms_pkg.sv -----
// ----------------------------------------------------------------------------
// pms_pkg
// Widths, limits and state codes for the prime modulus search block.
// ----------------------------------------------------------------------------
`default_nettype none

package pms_pkg;

   localparam int ORDER_W      = 16;                  // group order q
   localparam int MULT_W       = 16;                  // multiplier r on the result
   localparam int MOD_W        = 32;                  // modulus width, 8 .. 32
   localparam int MAX_MULT     = 65535;               // multiplier limit

   localparam int RCNT_W       = MULT_W + 1;          // holds the limit plus one
   localparam int CAND_W       = ORDER_W + RCNT_W;    // r*q+1 never overflows this
   localparam int DIV_W        = 17;                  // odd trial divisor
   localparam int DSQ_W        = 2 * DIV_W;           // its square
   localparam int REM_W        = DIV_W;               // remainder below the divisor
   localparam int BCNT_W       = $clog2(MOD_W);       // dividend bit counter

   localparam int REQ_DATA_W   = 16;
   localparam int RSP_DATA_W   = 56;

   localparam logic [CAND_W-1:0] MAX_P = CAND_W'((64'd1 << MOD_W) - 64'd1);
   localparam logic [RCNT_W-1:0] MAX_R = RCNT_W'(MAX_MULT);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_CHECK  = 7'b0000010,
      ST_TEST   = 7'b0000100,
      ST_DIV    = 7'b0001000,
      ST_DIVEND = 7'b0010000,
      ST_NEXT_R = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/prime_modulus_search.sv -----
// ----------------------------------------------------------------------------
// prime_modulus_search
// Finds the smallest r >= 1 for which r*q+1 is prime, by trial division.
// ----------------------------------------------------------------------------
// One request at a time. For each candidate p = r*q+1 the sequencer tries odd
// divisors d = 3, 5, 7, ... while d*d <= p; every trial runs p through a shared
// restoring divider, one bit of p per cycle. Even candidates other than 2, and 1,
// skip trial division and go straight to the next multiplier; a zero order walks
// every multiplier and ends not found. The next request is taken as soon as the
// result sits in the output register, even if it is not yet taken.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_modulus_search
   import pms_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // [15:0] group_order
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata   // [31:0] prime_modulus,
                                                  // [47:32] multiplier,
                                                  // [48] not_found, rest zero
);

   state_type             state_ff,   state_in;
   logic [ORDER_W-1:0]    q_ff,       q_in;
   logic [RCNT_W-1:0]     r_ff,       r_in;
   logic [CAND_W-1:0]     p_ff,       p_in;
   logic [DIV_W-1:0]      d_ff,       d_in;
   logic [DSQ_W-1:0]      dsq_ff,     dsq_in;
   logic [REM_W-1:0]      rem_ff,     rem_in;
   logic [MOD_W-1:0]      num_ff,     num_in;
   logic [BCNT_W-1:0]     bcnt_ff,    bcnt_in;
   logic                  nf_ff,      nf_in;
   logic                  rvalid_ff,  rvalid_in;
   logic [RSP_DATA_W-1:0] rdata_ff,   rdata_in;

   // shared divider step
   logic [REM_W:0]        rem_sh;
   logic [REM_W:0]        rem_sub;
   logic                  rem_ge;
   logic                  slot_free;

   assign rem_sh    = {rem_ff, num_ff[MOD_W-1]};
   assign rem_ge    = rem_sh >= (REM_W+1)'(d_ff);
   assign rem_sub   = rem_sh - (REM_W+1)'(d_ff);
   assign slot_free = !rvalid_ff || rsp_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;

   always_comb begin
      state_in  = state_ff;
      q_in      = q_ff;
      r_in      = r_ff;
      p_in      = p_ff;
      d_in      = d_ff;
      dsq_in    = dsq_ff;
      rem_in    = rem_ff;
      num_in    = num_ff;
      bcnt_in   = bcnt_ff;
      nf_in     = nf_ff;
      rvalid_in = rvalid_ff && !rsp_tready;
      rdata_in  = rdata_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               q_in     = req_tdata[ORDER_W-1:0];
               r_in     = RCNT_W'(1);
               p_in     = CAND_W'(req_tdata[ORDER_W-1:0]) + CAND_W'(1);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority if (r_ff > MAX_R || p_ff > MAX_P) begin
               nf_in    = 1'b1;
               state_in = ST_FINISH;
            end else if (p_ff == CAND_W'(2)) begin
               nf_in    = 1'b0;
               state_in = ST_FINISH;
            end else if (p_ff <= CAND_W'(1) || !p_ff[0]) begin
               state_in = ST_NEXT_R;
            end else begin
               d_in     = DIV_W'(3);
               dsq_in   = DSQ_W'(9);
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (dsq_ff > DSQ_W'(p_ff)) begin
               nf_in    = 1'b0;
               state_in = ST_FINISH;
            end else begin
               rem_in   = '0;
               num_in   = p_ff[MOD_W-1:0];
               bcnt_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = rem_ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
            num_in  = {num_ff[MOD_W-2:0], 1'b0};
            bcnt_in = bcnt_ff + BCNT_W'(1);
            if (bcnt_ff == BCNT_W'(MOD_W - 1)) begin
               state_in = ST_DIVEND;
            end
         end
         ST_DIVEND: begin
            if (rem_ff == '0) begin
               state_in = ST_NEXT_R;
            end else begin
               // (d+2)^2 = d^2 + 4d + 4
               d_in     = d_ff + DIV_W'(2);
               dsq_in   = dsq_ff + (DSQ_W'(d_ff) << 2) + DSQ_W'(4);
               state_in = ST_TEST;
            end
         end
         ST_NEXT_R: begin
            r_in     = r_ff + RCNT_W'(1);
            p_in     = p_ff + CAND_W'(q_ff);
            state_in = ST_CHECK;
         end
         ST_FINISH: begin
            if (slot_free) begin
               rvalid_in = 1'b1;
               rdata_in  = '0;
               if (nf_ff) begin
                  rdata_in[MOD_W+MULT_W] = 1'b1;
               end else begin
                  rdata_in[MOD_W-1:0]           = p_ff[MOD_W-1:0];
                  rdata_in[MOD_W+MULT_W-1:MOD_W] = r_ff[MULT_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
      end
      q_ff     <= q_in;
      r_ff     <= r_in;
      p_ff     <= p_in;
      d_ff     <= d_in;
      dsq_ff   <= dsq_in;
      rem_ff   <= rem_in;
      num_ff   <= num_in;
      bcnt_ff  <= bcnt_in;
      nf_ff    <= nf_in;
      rdata_ff <= rdata_in;
   end

endmodule

`default_nettype wire

// ----- rtl/pms_checker.sv -----
// ----------------------------------------------------------------------------
// pms_checker
// Port-level checks on the prime modulus search block.
// ----------------------------------------------------------------------------
`default_nettype none

module pms_checker
   import pms_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic                  nf;
   logic [MOD_W-1:0]      pm;
   logic [MULT_W-1:0]     mult;

   assign nf   = rsp_tdata[MOD_W+MULT_W];
   assign pm   = rsp_tdata[MOD_W-1:0];
   assign mult = rsp_tdata[MOD_W+MULT_W-1:MOD_W];

   // a stalled result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // not-found results carry zero modulus and multiplier
   a_nf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && nf |-> pm == '0 && mult == '0)
      else $error("not-found result has nonzero fields");

   // a found modulus is 2 or odd, with a nonzero multiplier
   a_found_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !nf |-> mult != '0 && (pm[0] || pm == MOD_W'(2)))
      else $error("found result is not a plausible prime");

   // a request accepted now cannot produce a result in the very next cycle
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared too early");

   // nothing is presented right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind prime_modulus_search pms_checker u_pms_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
